### sv/lwss_pkg.sv
`default_nettype none
// ============================================================================
// lwss_pkg: shared types and constants of the light and watering scheduler
//
// Register indexes, configuration and state records, item and result
// records, and the angle saturation helper.
// ============================================================================
package lwss_pkg;

    localparam int unsigned DurW    = 27;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned SampleW = 10;
    localparam int unsigned ThrW    = 10;
    localparam int unsigned AngleW  = 8;
    localparam int unsigned PairW   = 16;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = DurW;
    localparam int unsigned CmpW    = 16;

    localparam logic [AngleW-1:0] MaxAngle = 8'd180;

    // Scaling of the humidity compare: sample * 19 < threshold * 33.
    localparam logic [CmpW-1:0] SampleScale = 16'd19;
    localparam logic [CmpW-1:0] ThrScale    = 16'd33;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] RegManualMode   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegLightOnMs    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegLightOffMs   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegValveOpenMs  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegValveLockMs  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegHumThreshold = 3'd5;
    localparam logic [CfgIdxW-1:0] RegValveAngles  = 3'd6;
    localparam logic [CfgIdxW-1:0] RegLightAngles  = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [DurW-1:0]  RstLightOnMs   = 27'd57600000;
    localparam logic [DurW-1:0]  RstLightOffMs  = 27'd28800000;
    localparam logic [DurW-1:0]  RstValveOpenMs = 27'd5000;
    localparam logic [DurW-1:0]  RstValveLockMs = 27'd600000;
    localparam logic [ThrW-1:0]  RstThreshold   = 10'd120;
    localparam logic [PairW-1:0] RstAngles      = 16'd23085;

    // Input item kinds.
    localparam logic CmdTick   = 1'b0;
    localparam logic CmdManual = 1'b1;

    // Manual command targets.
    localparam logic TargetValve = 1'b0;
    localparam logic TargetLight = 1'b1;

    typedef struct packed {
        logic              manual_mode;
        logic [DurW-1:0]   light_on_ms;
        logic [DurW-1:0]   light_off_ms;
        logic [DurW-1:0]   valve_open_ms;
        logic [DurW-1:0]   valve_lockout_ms;
        logic [ThrW-1:0]   humidity_threshold;
        logic [PairW-1:0]  valve_angles;
        logic [PairW-1:0]  light_angles;
    } cfg_t;

    typedef struct packed {
        logic              light_state;
        logic [TimeW-1:0]  light_mark;
        logic              water_state;
        logic [TimeW-1:0]  water_mark;
    } sched_state_t;

    typedef struct packed {
        logic              command;
        logic [TimeW-1:0]  now_ms;
        logic [SampleW-1:0] air_sample;
        logic              target;
        logic [AngleW-1:0] angle;
    } item_t;

    // Declared highest field first, so the packed form matches the output
    // beat layout with valve_update in bit 0.
    typedef struct packed {
        logic              light_on;
        logic              watering_on;
        logic [AngleW-1:0] light_angle;
        logic              light_update;
        logic [AngleW-1:0] valve_angle;
        logic              valve_update;
    } result_t;

    function automatic logic [AngleW-1:0] sat_angle(input logic [AngleW-1:0] a);
        return (a > MaxAngle) ? MaxAngle : a;
    endfunction

endpackage
`default_nettype wire

### sv/lwss_step.sv
`default_nettype none
// ============================================================================
// lwss_step: next-state and result logic for one item
//
// Runs the light and valve schedule for a tick, or passes a manual command
// through to one servo, and forms the result beat.
// ============================================================================
module lwss_step
    import lwss_pkg::*;
(
    input  wire cfg_t         cfg,
    input  wire sched_state_t cur,
    input  wire item_t        item,
    output sched_state_t      nxt,
    output result_t           res
);

    logic [TimeW-1:0] light_elapsed;
    logic [TimeW-1:0] water_elapsed;
    logic [CmpW-1:0]  sample_scaled;
    logic [CmpW-1:0]  thr_scaled;
    logic             light_toggle;
    logic             valve_open;
    logic             valve_close;
    logic             changed;
    logic [AngleW-1:0] cmd_angle;

    assign light_elapsed = item.now_ms - cur.light_mark;
    assign water_elapsed = item.now_ms - cur.water_mark;
    assign sample_scaled = CmpW'(item.air_sample) * SampleScale;
    assign thr_scaled    = CmpW'(cfg.humidity_threshold) * ThrScale;
    assign cmd_angle     = sat_angle(item.angle);

    always_comb begin
        if (cur.light_state) begin
            light_toggle = light_elapsed > TimeW'(cfg.light_on_ms);
        end else begin
            light_toggle = light_elapsed > TimeW'(cfg.light_off_ms);
        end
    end

    // A valve that opens on this tick has zero elapsed time, so it can never
    // also close on the same tick; closing is only checked when it was open.
    assign valve_open  = !cur.water_state && (sample_scaled < thr_scaled)
                         && (water_elapsed > TimeW'(cfg.valve_lockout_ms));
    assign valve_close = cur.water_state
                         && (water_elapsed > TimeW'(cfg.valve_open_ms));

    always_comb begin
        nxt     = cur;
        res     = '0;
        changed = 1'b0;
        if (cfg.manual_mode) begin
            if (item.command == CmdManual) begin
                if (item.target == TargetValve) begin
                    res.valve_update = 1'b1;
                    res.valve_angle  = cmd_angle;
                end else begin
                    res.light_update = 1'b1;
                    res.light_angle  = cmd_angle;
                end
            end
        end else if (item.command == CmdTick) begin
            if (light_toggle) begin
                nxt.light_state = !cur.light_state;
                nxt.light_mark  = item.now_ms;
            end
            if (valve_open || valve_close) begin
                nxt.water_state = valve_open;
                nxt.water_mark  = item.now_ms;
            end
            changed = light_toggle || valve_open || valve_close;
            if (changed) begin
                res.valve_update = 1'b1;
                res.valve_angle  = nxt.water_state
                                 ? sat_angle(cfg.valve_angles[PairW-1:AngleW])
                                 : sat_angle(cfg.valve_angles[AngleW-1:0]);
                res.light_update = 1'b1;
                res.light_angle  = nxt.light_state
                                 ? sat_angle(cfg.light_angles[PairW-1:AngleW])
                                 : sat_angle(cfg.light_angles[AngleW-1:0]);
            end
        end
        res.watering_on = nxt.water_state;
        res.light_on    = nxt.light_state;
    end

endmodule
`default_nettype wire

### sv/light_and_watering_servo_scheduler.sv
`default_nettype none
// ============================================================================
// light_and_watering_servo_scheduler: servo scheduler for light and valve
//
// Top level: configuration registers, input register, schedule state and
// output register around the per-item step logic.
// ============================================================================
// Each input beat is either a time tick (tuser = 0) carrying the current
// millisecond time and a raw air humidity sample, or a manual servo command
// (tuser = 1) carrying a target servo and an angle. Every accepted beat
// produces exactly one output beat. In automatic mode a tick toggles the
// light after its on or off duration, opens the valve when the scaled
// humidity is below the threshold and the lockout has elapsed, and closes it
// after the open time; when anything changes both servo angles are reported.
// In manual mode a command writes its angle straight to one servo. The block
// takes one beat per clock cycle while the output side is ready: a beat is
// held in the input register, where its schedule step is evaluated and
// written into the state and the output register, which presents the
// result beat. A stalled output holds the beat in the input register, and
// the input side stops taking beats until the output register drains. The
// schedule state is updated at the same edge the result is registered, so
// the next beat always sees it. Configuration writes take effect at the
// next edge and should be made while no beat is in flight.
module light_and_watering_servo_scheduler
    import lwss_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,

    // Configuration write port.
    input  wire                 cfg_wr_en,
    input  wire [CfgIdxW-1:0]   cfg_addr,
    input  wire [CfgDataW-1:0]  cfg_wdata,

    // Input stream.
    input  wire                 s_tvalid,
    output logic                s_tready,
    // tdata, lowest bit up: now_ms[31:0], air_sample[41:32], target[42],
    // angle[50:43], zero fill[55:51].
    input  wire [55:0]          s_tdata,
    // tuser: command[0].
    input  wire                 s_tuser,

    // Result stream.
    output logic                m_tvalid,
    input  wire                 m_tready,
    // tdata, lowest bit up: valve_update[0], valve_angle[8:1],
    // light_update[9], light_angle[17:10], watering_on[18], light_on[19],
    // zero fill[23:20].
    output logic [23:0]         m_tdata
);

    cfg_t         cfg_reg;
    sched_state_t state_reg;
    sched_state_t state_next;
    item_t        item_reg;
    logic         in_valid_reg;
    result_t      result_reg;
    result_t      result_next;
    logic         out_valid_reg;
    logic         advance;

    // The held beat moves on when the output register is empty or is being
    // drained in this cycle; the input register refills whenever it moves.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.manual_mode        <= 1'b0;
            cfg_reg.light_on_ms        <= RstLightOnMs;
            cfg_reg.light_off_ms       <= RstLightOffMs;
            cfg_reg.valve_open_ms      <= RstValveOpenMs;
            cfg_reg.valve_lockout_ms   <= RstValveLockMs;
            cfg_reg.humidity_threshold <= RstThreshold;
            cfg_reg.valve_angles       <= RstAngles;
            cfg_reg.light_angles       <= RstAngles;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                RegManualMode:   cfg_reg.manual_mode        <= cfg_wdata[0];
                RegLightOnMs:    cfg_reg.light_on_ms        <= cfg_wdata;
                RegLightOffMs:   cfg_reg.light_off_ms       <= cfg_wdata;
                RegValveOpenMs:  cfg_reg.valve_open_ms      <= cfg_wdata;
                RegValveLockMs:  cfg_reg.valve_lockout_ms   <= cfg_wdata;
                RegHumThreshold: cfg_reg.humidity_threshold <= cfg_wdata[ThrW-1:0];
                RegValveAngles:  cfg_reg.valve_angles       <= cfg_wdata[PairW-1:0];
                RegLightAngles:  cfg_reg.light_angles       <= cfg_wdata[PairW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: the payload needs no reset, only its valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.command    <= s_tuser;
            item_reg.now_ms     <= s_tdata[31:0];
            item_reg.air_sample <= s_tdata[41:32];
            item_reg.target     <= s_tdata[42];
            item_reg.angle      <= s_tdata[50:43];
        end
    end

    lwss_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // Schedule state: lights off, valve closed, both marks at zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, result_reg};

endmodule
`default_nettype wire

### sim/light_and_watering_servo_scheduler_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// light_and_watering_servo_scheduler_tb: self-checking bench of the scheduler
//
// Drives tick and manual command beats through the input stream and writes
// the configuration port between phases. An in-bench copy of the schedule
// predicts every result beat, and each output beat is compared field by
// field. The bench runs directed cases first, then randomized traffic phases
// under several configurations with random sender gaps and receiver stalls.
// ============================================================================
module light_and_watering_servo_scheduler_tb;
    import lwss_pkg::*;

    localparam int unsigned HalfPeriod  = 6;
    localparam int unsigned ResetCycles = 11;
    localparam int unsigned DrainCycles = 4;
    localparam int unsigned StallLimit  = 1000;
    localparam int unsigned PhaseBeats  = 140;
    localparam int unsigned NumPhases   = 8;

    logic                aclk       = 1'b0;
    logic                aresetn    = 1'b0;
    logic                cfg_wr_en  = 1'b0;
    logic [CfgIdxW-1:0]  cfg_addr   = '0;
    logic [CfgDataW-1:0] cfg_wdata  = '0;
    logic                s_tvalid   = 1'b0;
    logic                s_tready;
    // tdata, lowest bit up: now_ms, air_sample, target, angle, zero fill.
    logic [55:0]         s_tdata    = '0;
    // tuser: command.
    logic                s_tuser    = 1'b0;
    logic                m_tvalid;
    logic                m_tready   = 1'b1;
    // tdata, lowest bit up: valve_update, valve_angle, light_update,
    // light_angle, watering_on, light_on, zero fill.
    logic [23:0]         m_tdata;

    light_and_watering_servo_scheduler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #HalfPeriod aclk = ~aclk;

    // Shadow copy of the configuration registers and the schedule state.
    // Both start at their reset values and follow every write and beat.
    cfg_t cfg_shadow = '{
        manual_mode:        1'b0,
        light_on_ms:        RstLightOnMs,
        light_off_ms:       RstLightOffMs,
        valve_open_ms:      RstValveOpenMs,
        valve_lockout_ms:   RstValveLockMs,
        humidity_threshold: RstThreshold,
        valve_angles:       RstAngles,
        light_angles:       RstAngles
    };
    sched_state_t sched = '0;

    // Servo results still owed by the block, oldest first.
    result_t servo_results_due[$];

    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;

    // Sender burst control and the running millisecond clock of the traffic.
    bit          sender_gaps = 1'b1;
    int unsigned burst_left  = 0;
    logic [31:0] clock_ms    = '0;

    // Receiver stall control: 0 always ready, 1 random, 2 rotating pattern.
    int unsigned rdy_mode    = 0;
    logic [7:0]  rdy_pattern = 8'hFF;
    logic [2:0]  rdy_phase   = '0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic logic [AngleW-1:0] clamp_deg(input logic [AngleW-1:0] a);
        return (a > 8'd180) ? 8'd180 : a;
    endfunction

    // Works out the result of one beat and advances the shadow schedule.
    function automatic result_t schedule_step(input item_t it);
        result_t     r;
        logic        changed;
        logic [31:0] light_elapsed;
        logic [31:0] water_elapsed;
        logic [31:0] scaled_sample;
        logic [31:0] scaled_thr;
        r       = '0;
        changed = 1'b0;
        if (cfg_shadow.manual_mode) begin
            // Manual mode: a command drives one servo, a tick does nothing.
            if (it.command == CmdManual) begin
                if (it.target == TargetValve) begin
                    r.valve_update = 1'b1;
                    r.valve_angle  = clamp_deg(it.angle);
                end else begin
                    r.light_update = 1'b1;
                    r.light_angle  = clamp_deg(it.angle);
                end
            end
        end else if (it.command == CmdTick) begin
            // The light steps first. Elapsed time wraps modulo 2^32 and a
            // duration has passed only when elapsed is strictly greater.
            light_elapsed = it.now_ms - sched.light_mark;
            if (!sched.light_state) begin
                if (light_elapsed > {5'd0, cfg_shadow.light_off_ms}) begin
                    sched.light_state = 1'b1;
                    sched.light_mark  = it.now_ms;
                    changed           = 1'b1;
                end
            end else if (light_elapsed > {5'd0, cfg_shadow.light_on_ms}) begin
                sched.light_state = 1'b0;
                sched.light_mark  = it.now_ms;
                changed           = 1'b1;
            end

            // The valve may open and then, on the same tick, be checked for
            // closing against the mark it just took.
            scaled_sample = {22'd0, it.air_sample} * 32'd19;
            scaled_thr    = {22'd0, cfg_shadow.humidity_threshold} * 32'd33;
            water_elapsed = it.now_ms - sched.water_mark;
            if (!sched.water_state && scaled_sample < scaled_thr &&
                water_elapsed > {5'd0, cfg_shadow.valve_lockout_ms}) begin
                sched.water_state = 1'b1;
                sched.water_mark  = it.now_ms;
                changed           = 1'b1;
            end
            water_elapsed = it.now_ms - sched.water_mark;
            if (sched.water_state &&
                water_elapsed > {5'd0, cfg_shadow.valve_open_ms}) begin
                sched.water_state = 1'b0;
                sched.water_mark  = it.now_ms;
                changed           = 1'b1;
            end

            // Any change reports both servos at their new positions.
            if (changed) begin
                r.valve_update = 1'b1;
                r.valve_angle  = clamp_deg(sched.water_state ?
                    cfg_shadow.valve_angles[15:8] : cfg_shadow.valve_angles[7:0]);
                r.light_update = 1'b1;
                r.light_angle  = clamp_deg(sched.light_state ?
                    cfg_shadow.light_angles[15:8] : cfg_shadow.light_angles[7:0]);
            end
        end
        r.watering_on = sched.water_state;
        r.light_on    = sched.light_state;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // One register write. The enable drops after each write so that it never
    // gets two assignments at the same edge.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            RegManualMode:   cfg_shadow.manual_mode        = val[0];
            RegLightOnMs:    cfg_shadow.light_on_ms        = val;
            RegLightOffMs:   cfg_shadow.light_off_ms       = val;
            RegValveOpenMs:  cfg_shadow.valve_open_ms      = val;
            RegValveLockMs:  cfg_shadow.valve_lockout_ms   = val;
            RegHumThreshold: cfg_shadow.humidity_threshold = val[ThrW-1:0];
            RegValveAngles:  cfg_shadow.valve_angles       = val[PairW-1:0];
            RegLightAngles:  cfg_shadow.light_angles       = val[PairW-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_config(input logic mode, input logic [DurW-1:0] on_ms,
                               input logic [DurW-1:0] off_ms,
                               input logic [DurW-1:0] open_ms,
                               input logic [DurW-1:0] lock_ms,
                               input logic [ThrW-1:0] thr,
                               input logic [PairW-1:0] valve_pair,
                               input logic [PairW-1:0] light_pair);
        write_reg(RegManualMode,   {26'd0, mode});
        write_reg(RegLightOnMs,    on_ms);
        write_reg(RegLightOffMs,   off_ms);
        write_reg(RegValveOpenMs,  open_ms);
        write_reg(RegValveLockMs,  lock_ms);
        write_reg(RegHumThreshold, {17'd0, thr});
        write_reg(RegValveAngles,  {11'd0, valve_pair});
        write_reg(RegLightAngles,  {11'd0, light_pair});
    endtask

    // Presents one beat, waits for it to be taken and records the result it
    // owes. Between bursts, when gaps are enabled, the sender drops tvalid.
    task automatic send_beat(input item_t it);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, it.angle, it.target, it.air_sample, it.now_ms};
        s_tuser  <= it.command;
        do @(posedge aclk); while (!s_tready);
        servo_results_due.push_back(schedule_step(it));
        if (sender_gaps) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(0, 20);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_tick(input logic [31:0] now, input logic [SampleW-1:0] sample);
        item_t it;
        it            = '0;
        it.command    = CmdTick;
        it.now_ms     = now;
        it.air_sample = sample;
        it.target     = 1'($urandom_range(0, 1));
        it.angle      = 8'($urandom_range(0, 255));
        send_beat(it);
    endtask

    task automatic send_command(input logic tgt, input logic [AngleW-1:0] deg);
        item_t it;
        it            = '0;
        it.command    = CmdManual;
        it.now_ms     = $urandom();
        it.air_sample = 10'($urandom_range(0, 1023));
        it.target     = tgt;
        it.angle      = deg;
        send_beat(it);
    endtask

    // Stops sending and waits until every owed result has come back, then
    // lets the pipeline settle before anything else happens.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (servo_results_due.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset configuration in automatic mode: the strict greater-than on the
    // light off time, the humidity threshold boundary, valve open and close,
    // a command that automatic mode ignores, and a time wrap.
    task automatic test_reset_schedule();
        send_tick(32'd0, 10'd1023);
        send_tick(32'd28800000, 10'd1023);      // equal to off time: no change
        send_tick(32'd28800001, 10'd1023);      // light turns on
        send_tick(32'd28800002, 10'd209);       // just at the threshold: closed
        send_tick(32'd28800003, 10'd208);       // just below: valve opens
        send_tick(32'd28805003, 10'd0);         // open time not yet exceeded
        send_tick(32'd28805004, 10'd0);         // valve closes
        send_tick(32'd28805010, 10'd0);         // lockout holds it closed
        send_command(TargetLight, 8'd255);      // ignored in automatic mode
        send_command(TargetValve, 8'd0);
        send_tick(32'hFFFF_FFFF, 10'd1023);     // huge elapsed: light off
        send_tick(32'd5, 10'd1023);             // wrapped time, short elapsed
        wait_all_results();
    endtask

    // Manual mode: each servo takes its command angle, saturated above 180,
    // and a tick leaves the schedule untouched.
    task automatic test_manual_commands();
        load_config(1'b1, RstLightOnMs, RstLightOffMs, RstValveOpenMs, RstValveLockMs,
                    RstThreshold, 16'd46260, 16'h00FF);
        send_command(TargetValve, 8'd0);
        send_command(TargetLight, 8'd255);
        send_command(TargetValve, 8'd181);
        send_command(TargetLight, 8'd180);
        send_tick(32'hFFFF_FFF0, 10'd0);
        wait_all_results();
    endtask

    // Zero durations and the threshold extremes: every tick with a new time
    // toggles the light, and the valve cycles as fast as it can.
    task automatic test_zero_durations();
        load_config(1'b0, 27'd0, 27'd0, 27'd0, 27'd0, 10'd999, 16'h00FF, 16'd46260);
        send_tick(32'd100, 10'd1023);
        send_tick(32'd100, 10'd1023);           // same time: nothing elapsed
        send_tick(32'd101, 10'd1023);
        send_tick(32'd102, 10'd1023);
        wait_all_results();
        write_reg(RegHumThreshold, 27'd0);      // threshold zero never waters
        send_tick(32'd200, 10'd0);
        send_tick(32'd300, 10'd0);
        wait_all_results();
    endtask

    // Randomized phases, each with its own configuration, sender burst
    // behavior and receiver stall mode. Time mostly advances in small steps
    // so the schedule keeps switching; a few beats jump to a random time.
    task automatic test_random_traffic();
        int unsigned  p;
        int unsigned  n;
        int unsigned  roll;
        int unsigned  step_cap;
        int unsigned  dur_cap;
        int unsigned  wet_limit;
        logic         mode;
        logic [ThrW-1:0] thr;
        logic [PairW-1:0] vpair;
        logic [PairW-1:0] lpair;
        item_t        it;
        for (p = 0; p < NumPhases; p++) begin
            wait_all_results();
            mode     = (p == 5);
            dur_cap  = 40;
            step_cap = 20;
            thr      = 10'($urandom_range(0, 999));
            vpair    = 16'($urandom_range(0, 46260));
            lpair    = 16'($urandom_range(0, 46260));
            case (p)
                0: begin
                    vpair = 16'd46260;
                    lpair = 16'd0;
                end
                1: begin
                    dur_cap = 0;
                    step_cap = 3;
                    thr = 10'd999;
                end
                2: begin
                    dur_cap = 99999999;
                    step_cap = 60000000;
                end
                3: thr = 10'd0;
                default: ;
            endcase
            if (p == 2) begin
                load_config(mode, 27'd99999999, 27'd99999999, 27'd99999999,
                            27'd99999999, thr, vpair, lpair);
            end else begin
                load_config(mode, 27'($urandom_range(0, dur_cap)),
                            27'($urandom_range(0, dur_cap)),
                            27'($urandom_range(0, dur_cap)),
                            27'($urandom_range(0, dur_cap)), thr, vpair, lpair);
            end
            sender_gaps = (p % 4 != 3);
            rdy_mode    = p % 3;
            rdy_pattern = 8'($urandom_range(0, 255)) | 8'h01;
            wet_limit   = (int'(thr) * 33) / 19;
            if (wet_limit > 1023) wet_limit = 1023;

            for (n = 0; n < PhaseBeats; n++) begin
                roll = $urandom_range(0, 99);
                // Occasionally hold off until every owed result is back.
                if (roll == 0) wait_all_results();
                if (roll < 6) clock_ms = $urandom();
                else clock_ms = clock_ms + 32'($urandom_range(0, step_cap));
                it            = '0;
                it.now_ms     = clock_ms;
                it.air_sample = ($urandom_range(0, 1) != 0) ?
                    10'($urandom_range(0, wet_limit)) : 10'($urandom_range(0, 1023));
                it.target     = 1'($urandom_range(0, 1));
                it.angle      = 8'($urandom_range(0, 255));
                roll          = $urandom_range(0, 99);
                it.command    = (mode ? (roll < 70) : (roll < 5)) ? CmdManual : CmdTick;
                send_beat(it);
            end
        end
        rdy_mode    = 0;
        sender_gaps = 1'b1;
        wait_all_results();
    endtask

    // ------------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------------

    // The receiver either stays ready, stalls at random or walks a rotating
    // ready pattern; the pattern always has at least one ready slot.
    always @(posedge aclk) begin
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= rdy_pattern[rdy_phase];
        endcase
        rdy_phase <= rdy_phase + 3'd1;
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    result_t got_result;
    result_t want_result;

    // Every accepted output beat is matched against the oldest owed result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result = m_tdata[19:0];
            if (servo_results_due.size() == 0) begin
                $display("%0t ns: result beat with none expected, expected nothing, actual %h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want_result = servo_results_due.pop_front();
                check_field("valve_update", 8'(want_result.valve_update),
                            8'(got_result.valve_update));
                check_field("valve_angle", want_result.valve_angle, got_result.valve_angle);
                check_field("light_update", 8'(want_result.light_update),
                            8'(got_result.light_update));
                check_field("light_angle", want_result.light_angle, got_result.light_angle);
                check_field("watering_on", 8'(want_result.watering_on),
                            8'(got_result.watering_on));
                check_field("light_on", 8'(want_result.light_on), 8'(got_result.light_on));
            end
        end
    end

    // Ends the run when no beat moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_schedule();
        test_manual_commands();
        test_zero_durations();
        test_random_traffic();

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
